### rtl/core/assert_macros.svh
// Assertion macros shared by the console RTL.
// Each macro checks on the rising clock edge, off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge.
`define CHK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Antecedent this cycle requires the consequent on the next edge.
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tcce_pkg.sv
`timescale 1ns / 1ps
// Package for the text console cursor engine: field widths, screen defaults,
// control codes and the sequencer state type. Depends on nothing.
package tcce_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int NCOL_W = 8;
   localparam int NROW_W = 6;
   localparam int IDX_W  = 11;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int HW_W   = 11;
   localparam int DATA_W = 16;
   localparam int ATTR_W = 7;

   localparam logic [ATTR_W-1:0] ATTR_RESET  = 7'h07;
   localparam logic [DATA_W-1:0] BLANK_RESET = 16'h0720;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // tab stops fall on multiples of four
   localparam logic [COL_W:0] TAB_MASK = ~(COL_W+1)'(3);

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT    = 2'd0,
      MODE_CURSOR = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLR_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_TAB,
      ST_FILL,
      ST_POST,
      ST_SCROLL,
      ST_BLANK,
      ST_HW
   } state_type;

endpackage

### rtl/core/text_console_cursor_engine_top.sv
`timescale 1ns / 1ps
// Flow: an accepted request passes through ST_EXEC, ST_POST and ST_HW, and rsp_valid
// is registered out of ST_HW. Tab adds ST_TAB; scroll adds ST_SCROLL, which moves the
// rows up, and ST_BLANK, which blanks the bottom row; clear adds ST_FILL. One cell write
// per cycle on the single screen RAM write port. A new request may be taken in the
// strobe cycle. Reset: synchronous; busy stays high while the screen is blanked.
// Results cannot be stalled. Depends on tcce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module text_console_cursor_engine_top
   import tcce_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_last_in_write,
   input  logic [NCOL_W-1:0] req_new_col,
   input  logic [NROW_W-1:0] req_new_row,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              rsp_valid,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [HW_W-1:0]   rsp_hw_cursor_pos,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_scrolled,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int MOVE  = (ROWS - 1) * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int LIN_W = AW + 1;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [CHAR_W-1:0]    ch_ff, ch_in;
   logic                 last_ff, last_in;
   logic [NCOL_W-1:0]    ncol_ff, ncol_in;
   logic [NROW_W-1:0]    nrow_ff, nrow_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [HW_W-1:0]      hw_ff, hw_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [COL_W:0]       tab_end_ff, tab_end_in;
   logic                 upd_ff, upd_in;
   logic                 scrolled_ff, scrolled_in;
   logic [DATA_W-1:0]    rdata_ff, rdata_in;
   logic                 valid_ff, valid_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic [ATTR_W-1:0]    attr_ff;

   logic [DATA_W-1:0]    mem [CELLS];
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_wa, mem_ra;
   logic [DATA_W-1:0]    mem_wd;

   logic [LIN_W-1:0]     lin;
   logic [DATA_W-1:0]    blank;
   logic                 idx_ok;
   logic                 row_ok;
   logic [COL_W:0]       col_nx;

   // shared address unit: linear cell position of the cursor
   assign lin    = LIN_W'(row_ff) * LIN_W'(COLUMNS) + LIN_W'(col_ff);
   assign blank  = {1'b0, attr_ff, CH_SPACE};
   assign idx_ok = (idx_ff < CELLS);
   assign row_ok = (row_ff < ROW_W'(ROWS));
   assign col_nx = {1'b0, col_ff} + (COL_W+1)'(1);

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = valid_ff;
   assign rsp_cursor_col    = col_ff;
   assign rsp_cursor_row    = row_ff;
   assign rsp_hw_cursor_pos = hw_ff;
   assign rsp_read_data     = rdata_ff;
   assign rsp_scrolled      = scrolled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLR_INIT;
         col_ff      <= '0;
         row_ff      <= '0;
         hw_ff       <= '0;
         cnt_ff      <= '0;
         upd_ff      <= 1'b0;
         scrolled_ff <= 1'b0;
         valid_ff    <= 1'b0;
         wr_pend_ff  <= 1'b0;
         attr_ff     <= ATTR_RESET;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         hw_ff       <= hw_in;
         cnt_ff      <= cnt_in;
         upd_ff      <= upd_in;
         scrolled_ff <= scrolled_in;
         valid_ff    <= valid_in;
         wr_pend_ff  <= wr_pend_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      ch_ff      <= ch_in;
      last_ff    <= last_in;
      ncol_ff    <= ncol_in;
      nrow_ff    <= nrow_in;
      idx_ff     <= idx_in;
      tab_end_ff <= tab_end_in;
      rdata_ff   <= rdata_in;
      wr_addr_ff <= wr_addr_in;
   end

   // screen RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      ch_in       = ch_ff;
      last_in     = last_ff;
      ncol_in     = ncol_ff;
      nrow_in     = nrow_ff;
      idx_in      = idx_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      hw_in       = hw_ff;
      cnt_in      = cnt_ff;
      tab_end_in  = tab_end_ff;
      upd_in      = upd_ff;
      scrolled_in = scrolled_ff;
      rdata_in    = rdata_ff;
      valid_in    = 1'b0;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      mem_we      = 1'b0;
      mem_wa      = '0;
      mem_wd      = blank;
      mem_re      = 1'b0;
      mem_ra      = '0;

      // retire a scroll move: the row below was read last cycle
      if (wr_pend_ff) begin
         mem_we = 1'b1;
         mem_wa = wr_addr_ff;
         mem_wd = rd_data_ff;
      end

      unique case (state_ff)
         ST_CLR_INIT: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = BLANK_RESET;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               mode_in     = mode_type'(req_mode);
               ch_in       = req_char_code;
               last_in     = req_last_in_write;
               ncol_in     = req_new_col;
               nrow_in     = req_new_row;
               idx_in      = req_cell_index;
               upd_in      = 1'b0;
               scrolled_in = 1'b0;
               rdata_in    = '0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_POST;
            unique case (mode_ff)
               MODE_PUT: begin
                  upd_in = last_ff;
                  unique case (ch_ff)
                     CH_CR: begin
                        col_in = '0;
                     end
                     CH_LF: begin
                        col_in = '0;
                        row_in = row_ff + ROW_W'(1);
                     end
                     CH_TAB: begin
                        tab_end_in = ({1'b0, col_ff} + (COL_W+1)'(4)) & TAB_MASK;
                        state_in   = ST_TAB;
                     end
                     CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - COL_W'(1);
                           if ((col_ff - COL_W'(1)) < COL_W'(COLUMNS) && row_ok) begin
                              mem_we = 1'b1;
                              mem_wa = AW'(lin - LIN_W'(1));
                           end
                        end
                     end
                     default: begin
                        if (col_ff < COL_W'(COLUMNS) && row_ok) begin
                           mem_we = 1'b1;
                           mem_wa = AW'(lin);
                           mem_wd = {1'b0, attr_ff, ch_ff};
                        end
                        // wrap to the next row at the right edge
                        if (col_nx >= (COL_W+1)'(COLUMNS)) begin
                           col_in = '0;
                           row_in = row_ff + ROW_W'(1);
                        end else begin
                           col_in = col_nx[COL_W-1:0];
                        end
                     end
                  endcase
               end
               MODE_CURSOR: begin
                  upd_in = 1'b1;
                  if (!ncol_ff[NCOL_W-1] && ncol_ff[COL_W-1:0] < COL_W'(COLUMNS)) begin
                     col_in = ncol_ff[COL_W-1:0];
                  end
                  if (!nrow_ff[NROW_W-1] && nrow_ff[ROW_W-1:0] < ROW_W'(ROWS)) begin
                     row_in = nrow_ff[ROW_W-1:0];
                  end
               end
               MODE_CLEAR: begin
                  upd_in   = 1'b1;
                  col_in   = '0;
                  row_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_FILL;
               end
               MODE_READ: begin
                  if (idx_ok) begin
                     mem_re = 1'b1;
                     mem_ra = AW'(idx_ff);
                  end
               end
            endcase
         end

         ST_TAB: begin
            if ({1'b0, col_ff} < tab_end_ff && col_ff < COL_W'(COLUMNS)) begin
               if (row_ok) begin
                  mem_we = 1'b1;
                  mem_wa = AW'(lin);
               end
               col_in = col_ff + COL_W'(1);
            end else begin
               state_in = ST_POST;
            end
         end

         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         ST_POST: begin
            if (mode_ff == MODE_READ && idx_ok) begin
               rdata_in = rd_data_ff;
            end
            // a scroll clamps both axes; an update (upd_ff) clamps only the column
            if (!row_ok) begin
               scrolled_in = 1'b1;
               row_in      = ROW_W'(ROWS - 1);
               cnt_in      = '0;
               state_in    = ST_SCROLL;
            end else begin
               state_in = ST_HW;
            end
            if (!row_ok || upd_ff) begin
               if (col_ff >= COL_W'(COLUMNS)) begin
                  col_in = COL_W'(COLUMNS - 1);
               end
            end
         end

         ST_SCROLL: begin
            if (cnt_ff < AW'(MOVE)) begin
               mem_re     = 1'b1;
               mem_ra     = cnt_ff + AW'(COLUMNS);
               wr_pend_in = 1'b1;
               wr_addr_in = cnt_ff;
               cnt_in     = cnt_ff + AW'(1);
            end else begin
               state_in = ST_BLANK;
            end
         end

         ST_BLANK: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_HW;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         ST_HW: begin
            if (upd_ff) begin
               hw_in = HW_W'(lin);
            end
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CHK_NEXT(a_take_sets_busy, start && !busy, busy, "request taken but busy stayed low")
   `CHK_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `CHK_ALWAYS(a_row_in_screen, !rsp_valid || (rsp_cursor_row < ROWS), "result row off screen")
   `CHK_ALWAYS(a_hw_in_screen, hw_ff < CELLS, "hardware cursor beyond last cell")
   `CHK_ALWAYS(a_write_in_screen, !mem_we || (mem_wa < CELLS), "cell write beyond screen")

endmodule
